// ----- rtl/flvm_pkg.sv -----
// shared constants and types for the flv tag muxer
package flvm_pkg;

  localparam int LENGTH_BITS_DEFAULT = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int PREFIX_BYTES = 15;
  localparam int IDX_W = $clog2(PREFIX_BYTES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PREFIX_BYTES);

  localparam logic [24:0] PREFIX_EXTRA = 25'd11;
  localparam logic [7:0] KEY_FRAME_BYTE = 8'h17;

  localparam logic [7:0] TYPE_NONE = 8'd0;
  localparam logic [7:0] TYPE_AUDIO = 8'd8;
  localparam logic [7:0] TYPE_VIDEO = 8'd9;
  localparam logic [7:0] TYPE_SCRIPT = 8'd18;

  typedef enum logic [2:0] {
    KIND_AUDIO     = 3'd0,
    KIND_VIDEO     = 3'd1,
    KIND_AUDIO_SEQ = 3'd2,
    KIND_VIDEO_SEQ = 3'd3,
    KIND_SCRIPT    = 3'd4
  } media_kind_t;

  typedef struct packed {
    logic        hdr;
    logic [24:0] prev_size;
    logic [7:0]  tag_type;
    logic [23:0] length;
    logic [31:0] ts;
    logic [7:0]  data;
    logic        last;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

endpackage

// ----- rtl/flvm_if.sv -----
// channel interfaces for media input and tag stream output
interface flvm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  media_kind;
  logic [31:0] timestamp;
  logic [23:0] payload_length;
  logic [7:0]  data_byte;
  logic        first_of_frame;
  logic        last_of_frame;

  modport source(output valid, media_kind, timestamp, payload_length, data_byte,
                 first_of_frame, last_of_frame, input ready);
  modport sink(input valid, media_kind, timestamp, payload_length, data_byte,
               first_of_frame, last_of_frame, output ready);
endinterface

interface flvm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       tag_end;

  modport source(output valid, out_byte, tag_end, input ready);
  modport sink(input valid, out_byte, tag_end, output ready);
endinterface

// ----- rtl/flvm_front.sv -----
// front end: frame tracking, filtering and tag classification
module flvm_front import flvm_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  flvm_in_if.sink      media_in,
  input  logic         q_full,
  output push_t        push_out
);

  logic [24:0]            prev_tag_size, prev_tag_size_next;
  logic                   video_header_seen, video_header_seen_next;
  logic                   key_frame_seen, key_frame_seen_next;
  logic                   dropping_frame, dropping_frame_next;
  logic [LENGTH_BITS-1:0] current_length, current_length_next;

  logic [LENGTH_BITS-1:0] len_in;
  logic [LENGTH_BITS-1:0] remain;
  logic                   drop;
  logic                   hdr;
  logic                   emit;
  logic                   last_v;
  logic [7:0]             tag_type;
  logic [31:0]            ts_v;
  logic                   accept;

  assign media_in.ready = !q_full;
  assign accept = media_in.valid && media_in.ready;
  assign len_in = media_in.payload_length[LENGTH_BITS-1:0];

  always_comb begin
    prev_tag_size_next = prev_tag_size;
    video_header_seen_next = video_header_seen;
    key_frame_seen_next = key_frame_seen;
    dropping_frame_next = dropping_frame;
    current_length_next = current_length;
    drop = 1'b0;
    hdr = 1'b0;
    emit = 1'b0;
    last_v = 1'b0;
    remain = '0;
    tag_type = TYPE_NONE;
    ts_v = media_in.timestamp;
    if (media_in.first_of_frame) begin
      current_length_next = '0;
      dropping_frame_next = 1'b0;
      if (len_in != '0) begin
        if (media_in.media_kind == KIND_VIDEO_SEQ) begin
          video_header_seen_next = 1'b1;
        end
        if (media_in.media_kind == KIND_VIDEO && !key_frame_seen && video_header_seen) begin
          if (media_in.data_byte == KEY_FRAME_BYTE) begin
            key_frame_seen_next = 1'b1;
          end else begin
            drop = 1'b1;
          end
        end
        case (media_in.media_kind)
          KIND_AUDIO, KIND_AUDIO_SEQ: tag_type = TYPE_AUDIO;
          KIND_VIDEO, KIND_VIDEO_SEQ: tag_type = TYPE_VIDEO;
          KIND_SCRIPT: begin
            tag_type = TYPE_SCRIPT;
            ts_v = '0;
          end
          default: drop = 1'b1;
        endcase
        current_length_next = len_in;
        dropping_frame_next = drop;
        hdr = !drop;
        if (!drop) begin
          prev_tag_size_next = PREFIX_EXTRA + 25'(len_in);
        end
      end
    end
    if (current_length_next != '0) begin
      remain = current_length_next - 1'b1;
      last_v = (remain == '0) || media_in.last_of_frame;
      emit = !dropping_frame_next;
      current_length_next = last_v ? '0 : remain;
      dropping_frame_next = last_v ? 1'b0 : dropping_frame_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_tag_size <= '0;
      video_header_seen <= 1'b0;
      key_frame_seen <= 1'b0;
      dropping_frame <= 1'b0;
      current_length <= '0;
    end else if (accept) begin
      prev_tag_size <= prev_tag_size_next;
      video_header_seen <= video_header_seen_next;
      key_frame_seen <= key_frame_seen_next;
      dropping_frame <= dropping_frame_next;
      current_length <= current_length_next;
    end
  end

  always_comb begin
    push_out.push = accept && emit;
    push_out.entry.hdr = hdr;
    push_out.entry.prev_size = prev_tag_size;
    push_out.entry.tag_type = tag_type;
    push_out.entry.length = 24'(len_in);
    push_out.entry.ts = ts_v;
    push_out.entry.data = media_in.data_byte;
    push_out.entry.last = last_v;
  end

endmodule

// ----- rtl/flvm_queue.sv -----
// small fifo between front and back ends
module flvm_queue import flvm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  push_t  push_in,
  output logic   full,
  output logic   rd_valid,
  output entry_t rd_entry,
  input  logic   pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_pop;

  assign full = (count == CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_entry = slots[rd_ptr];
  assign do_pop = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push_in.push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_in.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!push_in.push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_in.push) begin
      slots[wr_ptr] <= push_in.entry;
    end
  end

endmodule

// ----- rtl/flvm_back.sv -----
// back end: serializes tag prefix and payload bytes
module flvm_back import flvm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  entry_t     q_entry,
  output logic       pop,
  flvm_out_if.source tag_out
);

  entry_t                    ent;
  logic                      busy;
  logic [IDX_W-1:0]          idx;
  logic                      o_valid;
  logic [7:0]                o_byte;
  logic                      o_end;
  logic                      load;
  logic                      take;
  logic [PREFIX_BYTES*8-1:0] prefix;
  logic [7:0]                cur_byte;

  assign load = !o_valid || tag_out.ready;
  assign take = !busy || (load && idx == LAST_IDX);
  assign pop = take && q_valid;

  assign prefix = {7'd0, ent.prev_size, ent.tag_type, ent.length, ent.ts[23:0],
                   ent.ts[31:24], 24'd0};
  assign cur_byte = (idx == LAST_IDX) ? ent.data
                    : prefix[(PREFIX_BYTES - 1 - int'(idx)) * 8 +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
      o_valid <= 1'b0;
    end else begin
      if (load) begin
        o_valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
        idx <= q_entry.hdr ? '0 : LAST_IDX;
      end else if (busy && load) begin
        if (idx == LAST_IDX) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent <= q_entry;
    end
    if (busy && load) begin
      o_byte <= cur_byte;
      o_end <= (idx == LAST_IDX) && ent.last;
    end
  end

  assign tag_out.valid = o_valid;
  assign tag_out.out_byte = o_byte;
  assign tag_out.tag_end = o_end;

endmodule

// ----- rtl/flv_tag_muxer_top.sv -----
// flv tag muxer top level
// each kept frame's first byte yields 16 output bytes, later payload bytes one each
// payload bytes are accepted one per cycle; a tag prefix holds the back end while its 15 bytes go out
// and a four-entry queue absorbs input until it fills, then ready drops
// first output byte goes through a queue slot, the back-end entry register and the output register, no stall
// synchronous active-high reset clears frame state, the queue and the output register
module flv_tag_muxer_top import flvm_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  flvm_in_if.sink    media_in,
  flvm_out_if.source tag_out
);

  push_t  push;
  logic   q_full;
  logic   q_valid;
  entry_t q_entry;
  logic   pop;

  flvm_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .media_in (media_in),
    .q_full   (q_full),
    .push_out (push)
  );

  flvm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_in  (push),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_entry (q_entry),
    .pop      (pop)
  );

  flvm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .tag_out (tag_out)
  );

endmodule

// ----- rtl/flvm_checker.sv -----
// port-level checks for the flv tag muxer, bound to the top level
module flvm_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       tag_end
);

  // output register empties on reset
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // queue empties on reset so input is taken right away
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(tag_end))
    else $error("stalled output changed");

endmodule

bind flv_tag_muxer_top flvm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (media_in.ready),
  .out_valid (tag_out.valid),
  .out_ready (tag_out.ready),
  .out_byte  (tag_out.out_byte),
  .tag_end   (tag_out.tag_end)
);
